FILE: hw/rtl/efl_pkg.sv
// shared types and constants for the escaped frame link
// operation and status codes, controller/datapath command and status structs
// no dependencies
package efl_pkg;

  localparam int BufDepthDefault = 64;

  localparam int CodeW = 8;
  localparam int CapW  = 7;
  localparam int CntW  = 7;
  localparam int IdxW  = 6;

  localparam logic [CodeW-1:0] StartReset  = 8'hFE;
  localparam logic [CodeW-1:0] StopReset   = 8'hFF;
  localparam logic [CodeW-1:0] EscapeReset = 8'hFD;
  localparam logic [CapW-1:0]  CapReset    = 7'd64;

  localparam logic [CodeW-1:0] Bit7Mask = 8'h80;
  localparam logic [CodeW-1:0] Low7Mask = 8'h7F;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_STOP   = 2'd1,
    REG_ESCAPE = 2'd2,
    REG_CAP    = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    OP_LINE   = 3'd0,
    OP_BEGIN  = 3'd1,
    OP_BYTE   = 3'd2,
    OP_END    = 3'd3,
    OP_CHECK  = 3'd4,
    OP_STATUS = 3'd5,
    OP_PEEK   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LOCKED   = 3'd1,
    ST_ABORTED  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_NO_DATA  = 3'd4
  } status_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic emit_second;
    logic walk_read;
    logic walk_step;
    logic check_push;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic two_results;
    logic walk_start;
    logic walk_mismatch;
    logic walk_end;
  } sts_t;

endpackage

FILE: hw/rtl/escaped_frame_link_with_echo_check.sv
// top level of the escaped frame link with echo check
// the item is registered at transfer; its result is registered once the output is free
// one item at a time: a new item is accepted only after the last one is done;
//   an escaped send byte yields two results; a send check walks the stores entry by entry
// reset: synchronous active-low rst_n clears control state and restores default codes;
//   store contents stay undefined until written
module escaped_frame_link_with_echo_check #(
  parameter int BUF_DEPTH = efl_pkg::BufDepthDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [efl_pkg::CodeW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_op,
  input  logic [efl_pkg::CodeW-1:0] in_data_byte,
  input  logic [efl_pkg::IdxW-1:0]  in_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_line_valid,
  output logic [efl_pkg::CodeW-1:0] out_line_byte,
  output logic [2:0]                out_status,
  output logic [efl_pkg::CntW-1:0]  out_frame_length,
  output logic [efl_pkg::CodeW-1:0] out_peek_byte,
  output logic                      out_driver_enable,
  output logic                      out_last
);

  efl_pkg::cmd_t cmd;
  efl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  efl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  efl_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_op),
    .in_data_byte      (in_data_byte),
    .in_index          (in_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_valid    (out_line_valid),
    .out_line_byte     (out_line_byte),
    .out_status        (out_status),
    .out_frame_length  (out_frame_length),
    .out_peek_byte     (out_peek_byte),
    .out_driver_enable (out_driver_enable),
    .out_last          (out_last)
  );

endmodule

FILE: hw/rtl/efl_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module efl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/efl_ctrl.sv
// controller for the escaped frame link: item sequencing and store walk
// depends on efl_pkg
module efl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  efl_pkg::sts_t sts,
  output efl_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SECOND,
    S_WALK_RD,
    S_WALK_CMP,
    S_CHECK_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = 1'b0;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid && in_ready_r;
        if (cmd.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.walk_start) begin
          state_nxt = S_WALK_RD;
        end else if (sts.out_free) begin
          cmd.exec = 1'b1;
          state_nxt = sts.two_results ? S_SECOND : S_IDLE;
        end
      end
      S_SECOND: begin
        if (sts.out_free) begin
          cmd.emit_second = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WALK_RD: begin
        cmd.walk_read = 1'b1;
        state_nxt = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        cmd.walk_step = 1'b1;
        state_nxt = (sts.walk_mismatch || sts.walk_end) ? S_CHECK_OUT : S_WALK_RD;
      end
      S_CHECK_OUT: begin
        if (sts.out_free) begin
          cmd.check_push = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

FILE: hw/rtl/efl_dp.sv
// datapath for the escaped frame link: config, framing state, stores, result register
// depends on efl_pkg and efl_ram
module efl_dp #(
  parameter int BUF_DEPTH = efl_pkg::BufDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  efl_pkg::cmd_t               cmd,
  output efl_pkg::sts_t               sts,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [efl_pkg::CodeW-1:0]   cfg_data,
  input  logic [2:0]                  in_op,
  input  logic [efl_pkg::CodeW-1:0]   in_data_byte,
  input  logic [efl_pkg::IdxW-1:0]    in_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_line_valid,
  output logic [efl_pkg::CodeW-1:0]   out_line_byte,
  output logic [2:0]                  out_status,
  output logic [efl_pkg::CntW-1:0]    out_frame_length,
  output logic [efl_pkg::CodeW-1:0]   out_peek_byte,
  output logic                        out_driver_enable,
  output logic                        out_last
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int DW = efl_pkg::CodeW;
  localparam int FW = efl_pkg::CntW;

  // item registers
  efl_pkg::op_t              op_r, op_nxt;
  logic [DW-1:0]             data_r, data_nxt;
  logic [efl_pkg::IdxW-1:0]  idx_r, idx_nxt;

  // configuration
  logic [DW-1:0]             start_r, stop_r, esc_r;
  logic [efl_pkg::CapW-1:0]  cap_r;

  // link state
  logic [CW-1:0]             rc_r, rc_nxt;
  logic [CW-1:0]             tc_r, tc_nxt;
  logic                      frame_ready_r, frame_ready_nxt;
  logic                      overflow_r, overflow_nxt;
  logic                      frame_open_r, frame_open_nxt;
  logic                      esc_seen_r, esc_seen_nxt;
  logic                      sending_r, sending_nxt;
  logic                      drv_r, drv_nxt;
  logic [AW-1:0]             ptr_r, ptr_nxt;
  logic                      fail_r, fail_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_lv_r;
  logic [DW-1:0]             out_lb_r;
  logic [2:0]                out_st_r;
  logic [FW-1:0]             out_fl_r;
  logic [DW-1:0]             out_pb_r;
  logic                      out_drv_r;
  logic                      out_last_r;

  logic                      res_lv;
  logic [DW-1:0]             res_lb;
  efl_pkg::status_t          res_st;
  logic [FW-1:0]             res_fl;
  logic [DW-1:0]             res_pb;
  logic                      res_last;

  // stores
  logic                      rx_we, tx_we, rd_en;
  logic [AW-1:0]             rx_raddr, tx_raddr;
  logic [DW-1:0]             rx_q, tx_q;

  logic [DW-1:0]             pay_byte;
  logic                      echo_bad, rx_room, tx_full, special, push, out_free;

  assign pay_byte = esc_seen_r ? (data_r | efl_pkg::Bit7Mask) : data_r;
  assign echo_bad = (32'(rc_r) >= 32'(tc_r)) || (32'(rc_r) >= 32'(BUF_DEPTH))
                    || (tx_q != pay_byte);
  assign rx_room  = (32'(rc_r) < 32'(cap_r)) && (32'(rc_r) < 32'(BUF_DEPTH));
  assign tx_full  = 32'(tc_r) >= 32'(BUF_DEPTH);
  assign special  = (data_r == start_r) || (data_r == stop_r) || (data_r == esc_r);

  assign push     = cmd.exec || cmd.emit_second || cmd.check_push;
  assign out_free = !out_valid_r || out_ready;

  assign sts.out_free      = out_free;
  assign sts.two_results   = (op_r == efl_pkg::OP_BYTE) && sending_r && !tx_full
                             && drv_r && special;
  assign sts.walk_start    = (op_r == efl_pkg::OP_CHECK) && sending_r && drv_r
                             && (tc_r != '0);
  assign sts.walk_mismatch = rx_q != tx_q;
  assign sts.walk_end      = (CW'(ptr_r) + CW'(1)) == tc_r;

  // read ports: item index and receive count at transfer, walk pointer during the check
  assign rd_en    = cmd.accept || cmd.walk_read;
  assign rx_raddr = cmd.walk_read ? ptr_r : AW'(in_index);
  assign tx_raddr = cmd.walk_read ? ptr_r : AW'(rc_r);

  always_comb begin
    op_nxt          = op_r;
    data_nxt        = data_r;
    idx_nxt         = idx_r;
    rc_nxt          = rc_r;
    tc_nxt          = tc_r;
    frame_ready_nxt = frame_ready_r;
    overflow_nxt    = overflow_r;
    frame_open_nxt  = frame_open_r;
    esc_seen_nxt    = esc_seen_r;
    sending_nxt     = sending_r;
    drv_nxt         = drv_r;
    ptr_nxt         = ptr_r;
    fail_nxt        = fail_r;
    rx_we           = 1'b0;
    tx_we           = 1'b0;
    res_lv          = 1'b0;
    res_lb          = '0;
    res_st          = efl_pkg::ST_OK;
    res_fl          = '0;
    res_pb          = '0;
    res_last        = 1'b1;

    if (cmd.accept) begin
      op_nxt   = efl_pkg::op_t'(in_op);
      data_nxt = in_data_byte;
      idx_nxt  = in_index;
      ptr_nxt  = '0;
      fail_nxt = 1'b0;
    end

    if (cmd.walk_step) begin
      ptr_nxt = ptr_r + AW'(1);
      if (rx_q != tx_q) begin
        fail_nxt = 1'b1;
      end
    end

    if (cmd.emit_second) begin
      res_lv = 1'b1;
      res_lb = data_r & efl_pkg::Low7Mask;
    end

    if (cmd.check_push) begin
      res_st      = fail_r ? efl_pkg::ST_ABORTED : efl_pkg::ST_OK;
      sending_nxt = 1'b0;
      drv_nxt     = 1'b0;
    end

    if (cmd.exec) begin
      case (op_r)
        efl_pkg::OP_LINE: begin
          if (data_r == start_r) begin
            if (frame_ready_r) begin
              overflow_nxt    = 1'b1;
              frame_ready_nxt = 1'b0;
            end
            rc_nxt         = '0;
            frame_open_nxt = 1'b1;
          end else if (data_r == stop_r) begin
            if (!sending_r) begin
              frame_ready_nxt = 1'b1;
            end
            frame_open_nxt = 1'b0;
          end else if (data_r == esc_r) begin
            esc_seen_nxt = 1'b1;
          end else begin
            esc_seen_nxt = 1'b0;
            if (sending_r && echo_bad) begin
              drv_nxt = 1'b0;
            end
            if (rx_room) begin
              rx_we  = 1'b1;
              rc_nxt = rc_r + CW'(1);
            end
          end
        end
        efl_pkg::OP_BEGIN: begin
          if (frame_open_r || frame_ready_r || sending_r) begin
            res_st = efl_pkg::ST_LOCKED;
          end else begin
            sending_nxt = 1'b1;
            drv_nxt     = 1'b1;
            tc_nxt      = '0;
            res_lv      = 1'b1;
            res_lb      = start_r;
          end
        end
        efl_pkg::OP_BYTE: begin
          if (!sending_r) begin
            res_st = efl_pkg::ST_LOCKED;
          end else if (tx_full) begin
            res_st = efl_pkg::ST_OVERFLOW;
          end else begin
            tx_we  = 1'b1;
            tc_nxt = tc_r + CW'(1);
            if (drv_r) begin
              res_lv = 1'b1;
              if (special) begin
                res_lb   = esc_r;
                res_last = 1'b0;
              end else begin
                res_lb = data_r;
              end
            end
          end
        end
        efl_pkg::OP_END: begin
          if (!sending_r) begin
            res_st = efl_pkg::ST_LOCKED;
          end else begin
            res_lv = 1'b1;
            res_lb = stop_r;
          end
        end
        efl_pkg::OP_CHECK: begin
          // no send active, driver off or empty transmit store, no walk needed
          res_st      = (sending_r && drv_r) ? efl_pkg::ST_OK : efl_pkg::ST_ABORTED;
          sending_nxt = 1'b0;
          drv_nxt     = 1'b0;
        end
        efl_pkg::OP_STATUS: begin
          if (overflow_r) begin
            overflow_nxt = 1'b0;
            res_st       = efl_pkg::ST_OVERFLOW;
          end else if (frame_ready_r) begin
            frame_ready_nxt = 1'b0;
            res_fl          = FW'(rc_r);
          end else begin
            res_st = efl_pkg::ST_NO_DATA;
          end
        end
        efl_pkg::OP_PEEK: begin
          res_pb = (32'(idx_r) < 32'(BUF_DEPTH)) ? rx_q : '0;
        end
        default: begin
        end
      endcase
    end

    out_valid_nxt = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  efl_ram #(
    .WIDTH (DW),
    .DEPTH (BUF_DEPTH)
  ) u_rx_store (
    .clk   (clk),
    .we    (rx_we),
    .waddr (AW'(rc_r)),
    .wdata (pay_byte),
    .re    (rd_en),
    .raddr (rx_raddr),
    .rdata (rx_q)
  );

  efl_ram #(
    .WIDTH (DW),
    .DEPTH (BUF_DEPTH)
  ) u_tx_store (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tc_r[AW-1:0]),
    .wdata (data_r),
    .re    (rd_en),
    .raddr (tx_raddr),
    .rdata (tx_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= efl_pkg::StartReset;
      stop_r        <= efl_pkg::StopReset;
      esc_r         <= efl_pkg::EscapeReset;
      cap_r         <= efl_pkg::CapReset;
      rc_r          <= '0;
      tc_r          <= '0;
      frame_ready_r <= 1'b0;
      overflow_r    <= 1'b0;
      frame_open_r  <= 1'b0;
      esc_seen_r    <= 1'b0;
      sending_r     <= 1'b0;
      drv_r         <= 1'b0;
      ptr_r         <= '0;
      fail_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (efl_pkg::reg_t'(cfg_index))
          efl_pkg::REG_START:  start_r <= cfg_data;
          efl_pkg::REG_STOP:   stop_r  <= cfg_data;
          efl_pkg::REG_ESCAPE: esc_r   <= cfg_data;
          efl_pkg::REG_CAP:    cap_r   <= cfg_data[efl_pkg::CapW-1:0];
          default: begin
          end
        endcase
      end
      rc_r          <= rc_nxt;
      tc_r          <= tc_nxt;
      frame_ready_r <= frame_ready_nxt;
      overflow_r    <= overflow_nxt;
      frame_open_r  <= frame_open_nxt;
      esc_seen_r    <= esc_seen_nxt;
      sending_r     <= sending_nxt;
      drv_r         <= drv_nxt;
      ptr_r         <= ptr_nxt;
      fail_r        <= fail_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // item and result payload, no reset
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    data_r <= data_nxt;
    idx_r  <= idx_nxt;
    if (push) begin
      out_lv_r   <= res_lv;
      out_lb_r   <= res_lb;
      out_st_r   <= res_st;
      out_fl_r   <= res_fl;
      out_pb_r   <= res_pb;
      out_drv_r  <= drv_nxt;
      out_last_r <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_valid    = out_lv_r;
  assign out_line_byte     = out_lb_r;
  assign out_status        = out_st_r;
  assign out_frame_length  = out_fl_r;
  assign out_peek_byte     = out_pb_r;
  assign out_driver_enable = out_drv_r;
  assign out_last          = out_last_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed over a pending result");

  a_drv_send: assert property (@(posedge clk) disable iff (!rst_n)
    drv_r |-> sending_r)
    else $error("driver enabled outside a send");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(tc_r) <= 32'(BUF_DEPTH)) && (32'(rc_r) <= 32'(BUF_DEPTH)))
    else $error("store count beyond depth");

  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.two_results) |=> (out_valid_r && !out_last_r))
    else $error("escape byte not marked as first of two");

endmodule

FILE: tb/tb.sv
// self-checking testbench for escaped_frame_link_with_echo_check
// a cycle-free model of the link predicts every result, compared field by field in order
// depends on efl_pkg and the top level only
module tb;

  localparam int Depth = efl_pkg::BufDepthDefault;
  localparam logic [2:0] OpUndef = 3'd7;

  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic [2:0] status;
    logic [6:0] frame_length;
    logic [7:0] peek_byte;
    logic       driver_enable;
    logic       last;
  } link_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_op = '0;
  logic [7:0] in_data_byte = '0;
  logic [5:0] in_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_line_valid;
  logic [7:0] out_line_byte;
  logic [2:0] out_status;
  logic [6:0] out_frame_length;
  logic [7:0] out_peek_byte;
  logic       out_driver_enable;
  logic       out_last;

  escaped_frame_link_with_echo_check u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_valid   (out_line_valid),
    .out_line_byte    (out_line_byte),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_peek_byte    (out_peek_byte),
    .out_driver_enable(out_driver_enable),
    .out_last         (out_last)
  );

  // link model state
  logic [7:0] code_start  = efl_pkg::StartReset;
  logic [7:0] code_stop   = efl_pkg::StopReset;
  logic [7:0] code_escape = efl_pkg::EscapeReset;
  logic [6:0] rx_capacity = efl_pkg::CapReset;
  logic [7:0] rx_mem [Depth];
  logic [7:0] tx_mem [Depth];
  bit         rx_written [Depth];
  int         rx_count = 0;
  int         tx_count = 0;
  bit         rx_ready = 0;
  bit         rx_overflow = 0;
  bit         rx_open = 0;
  bit         esc_pending = 0;
  bit         tx_active = 0;
  bit         drv_on = 0;

  link_out_t  link_out_due [$];
  logic [7:0] bus_echo [$];
  int         items_sent = 0;
  int         errors = 0;
  bit         idling = 1;
  int         stall_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    link_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (link_out_due.size() == 0) begin
        report_mismatch("result transfer with none due", 1, 0);
      end else begin
        want = link_out_due.pop_front();
        if (out_line_valid !== want.line_valid)
          report_mismatch("line_valid", out_line_valid, want.line_valid);
        if (out_line_byte !== want.line_byte)
          report_mismatch("line_byte", out_line_byte, want.line_byte);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_frame_length !== want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
        if (out_peek_byte !== want.peek_byte)
          report_mismatch("peek_byte", out_peek_byte, want.peek_byte);
        if (out_driver_enable !== want.driver_enable)
          report_mismatch("driver_enable", out_driver_enable, want.driver_enable);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  function automatic bit is_code(input logic [7:0] v);
    return v == code_start || v == code_stop || v == code_escape;
  endfunction

  function automatic link_out_t link_result(input logic lv, input logic [7:0] lb,
                                            input logic [2:0] st, input logic [6:0] fl,
                                            input logic [7:0] pb, input logic lst);
    link_out_t r;
    r.line_valid    = lv;
    r.line_byte     = lb;
    r.status        = st;
    r.frame_length  = fl;
    r.peek_byte     = pb;
    r.driver_enable = drv_on;
    r.last          = lst;
    return r;
  endfunction

  task automatic advance_link(input logic [2:0] op, input logic [7:0] d, input logic [5:0] idx);
    logic [7:0] b;
    logic [2:0] st;
    int cap;
    int i;
    case (op)
      efl_pkg::OP_LINE: begin
        if (d == code_start) begin
          if (rx_ready) begin
            rx_overflow = 1;
            rx_ready = 0;
          end
          rx_count = 0;
          rx_open = 1;
        end else if (d == code_stop) begin
          if (!tx_active) rx_ready = 1;
          rx_open = 0;
        end else if (d == code_escape) begin
          esc_pending = 1;
        end else begin
          cap = (rx_capacity > Depth) ? Depth : rx_capacity;
          b = d;
          if (esc_pending) begin
            b = d | efl_pkg::Bit7Mask;
            esc_pending = 0;
          end
          if (tx_active && (rx_count >= tx_count || rx_count >= Depth || tx_mem[rx_count] != b))
            drv_on = 0;
          if (rx_count < cap) begin
            rx_mem[rx_count] = b;
            rx_written[rx_count] = 1;
            rx_count++;
          end
        end
        link_out_due.push_back(link_result(0, 0, efl_pkg::ST_OK, 0, 0, 1));
      end
      efl_pkg::OP_BEGIN: begin
        if (rx_open || rx_ready || tx_active) begin
          link_out_due.push_back(link_result(0, 0, efl_pkg::ST_LOCKED, 0, 0, 1));
        end else begin
          tx_active = 1;
          drv_on = 1;
          tx_count = 0;
          link_out_due.push_back(link_result(1, code_start, efl_pkg::ST_OK, 0, 0, 1));
          bus_echo.push_back(code_start);
        end
      end
      efl_pkg::OP_BYTE: begin
        if (!tx_active) begin
          link_out_due.push_back(link_result(0, 0, efl_pkg::ST_LOCKED, 0, 0, 1));
        end else if (tx_count >= Depth) begin
          link_out_due.push_back(link_result(0, 0, efl_pkg::ST_OVERFLOW, 0, 0, 1));
        end else begin
          tx_mem[tx_count] = d;
          tx_count++;
          if (!drv_on) begin
            link_out_due.push_back(link_result(0, 0, efl_pkg::ST_OK, 0, 0, 1));
          end else if (is_code(d)) begin
            link_out_due.push_back(link_result(1, code_escape, efl_pkg::ST_OK, 0, 0, 0));
            link_out_due.push_back(link_result(1, d & efl_pkg::Low7Mask, efl_pkg::ST_OK,
                                               0, 0, 1));
            bus_echo.push_back(code_escape);
            bus_echo.push_back(d & efl_pkg::Low7Mask);
          end else begin
            link_out_due.push_back(link_result(1, d, efl_pkg::ST_OK, 0, 0, 1));
            bus_echo.push_back(d);
          end
        end
      end
      efl_pkg::OP_END: begin
        if (!tx_active) begin
          link_out_due.push_back(link_result(0, 0, efl_pkg::ST_LOCKED, 0, 0, 1));
        end else begin
          link_out_due.push_back(link_result(1, code_stop, efl_pkg::ST_OK, 0, 0, 1));
          bus_echo.push_back(code_stop);
        end
      end
      efl_pkg::OP_CHECK: begin
        st = efl_pkg::ST_ABORTED;
        if (tx_active && drv_on) begin
          st = efl_pkg::ST_OK;
          for (i = 0; i < tx_count && i < Depth; i++) begin
            if (rx_mem[i] != tx_mem[i]) begin
              st = efl_pkg::ST_ABORTED;
              break;
            end
          end
        end
        drv_on = 0;
        tx_active = 0;
        link_out_due.push_back(link_result(0, 0, st, 0, 0, 1));
      end
      efl_pkg::OP_STATUS: begin
        if (rx_overflow) begin
          rx_overflow = 0;
          link_out_due.push_back(link_result(0, 0, efl_pkg::ST_OVERFLOW, 0, 0, 1));
        end else if (rx_ready) begin
          rx_ready = 0;
          link_out_due.push_back(link_result(0, 0, efl_pkg::ST_OK, 7'(rx_count), 0, 1));
        end else begin
          link_out_due.push_back(link_result(0, 0, efl_pkg::ST_NO_DATA, 0, 0, 1));
        end
      end
      efl_pkg::OP_PEEK: begin
        link_out_due.push_back(link_result(0, 0, efl_pkg::ST_OK, 0, rx_mem[idx], 1));
      end
      default: begin
        link_out_due.push_back(link_result(0, 0, efl_pkg::ST_OK, 0, 0, 1));
      end
    endcase
  endtask

  task automatic transfer_item(input logic [2:0] op, input logic [7:0] d, input logic [5:0] idx);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    advance_link(op, d, idx);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= d;
    in_index     <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // keeps peeks and send checks away from store entries never written
  task automatic send_item(input logic [2:0] op, input logic [7:0] d, input logic [5:0] idx);
    int base;
    int k;
    bit unsafe;
    logic [7:0] v;
    logic [7:0] eff;
    if (op == efl_pkg::OP_PEEK && !rx_written[idx]) begin
      base = $urandom_range(0, Depth - 1);
      op = efl_pkg::OP_STATUS;
      for (k = 0; k < Depth; k++) begin
        if (rx_written[(base + k) % Depth]) begin
          op = efl_pkg::OP_PEEK;
          idx = 6'((base + k) % Depth);
          break;
        end
      end
    end
    if (op == efl_pkg::OP_CHECK && tx_active && drv_on) begin
      unsafe = 0;
      for (k = 0; k < tx_count && k < Depth; k++)
        if (!rx_written[k]) unsafe = 1;
      if (unsafe) begin
        base = $urandom;
        v = 8'(base);
        for (k = 0; k < 256; k++) begin
          v = 8'(base + k);
          eff = esc_pending ? (v | efl_pkg::Bit7Mask) : v;
          if (!is_code(v) &&
              (rx_count >= tx_count || rx_count >= Depth || tx_mem[rx_count] != eff))
            break;
        end
        transfer_item(efl_pkg::OP_LINE, v, $urandom);
      end
    end
    transfer_item(op, d, idx);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (link_out_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input efl_pkg::reg_t r, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      efl_pkg::REG_START:  code_start = v;
      efl_pkg::REG_STOP:   code_stop = v;
      efl_pkg::REG_ESCAPE: code_escape = v;
      efl_pkg::REG_CAP:    rx_capacity = v[6:0];
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] s, input logic [7:0] p, input logic [7:0] e,
                           input logic [7:0] cap);
    wait_idle();
    write_reg(efl_pkg::REG_START, s);
    write_reg(efl_pkg::REG_STOP, p);
    write_reg(efl_pkg::REG_ESCAPE, e);
    write_reg(efl_pkg::REG_CAP, cap);
    cfg_valid <= 1'b0;
  endtask

  // feed emitted line bytes back as received bytes, with optional corruption and drops
  task automatic echo_line(input int noise_pct);
    logic [7:0] b;
    while (bus_echo.size() != 0) begin
      b = bus_echo.pop_front();
      if ($urandom_range(0, 99) < noise_pct) b ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 99) >= noise_pct / 2) send_item(efl_pkg::OP_LINE, b, $urandom);
    end
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 8);
  endfunction

  task automatic rx_frame_seq(input int len);
    logic [7:0] d;
    int j;
    send_item(efl_pkg::OP_LINE, code_start, $urandom);
    for (j = 0; j < len; j++) begin
      do d = 8'($urandom); while (is_code(d) || is_code(d & efl_pkg::Low7Mask));
      if ($urandom_range(0, 4) == 0) begin
        send_item(efl_pkg::OP_LINE, code_escape, $urandom);
        send_item(efl_pkg::OP_LINE, d & efl_pkg::Low7Mask, $urandom);
      end else begin
        send_item(efl_pkg::OP_LINE, d, $urandom);
      end
    end
    if ($urandom_range(0, 9) != 0) send_item(efl_pkg::OP_LINE, code_stop, $urandom);
    if ($urandom_range(0, 3) != 0) send_item(efl_pkg::OP_STATUS, $urandom, $urandom);
    repeat ($urandom_range(0, 2))
      send_item(efl_pkg::OP_PEEK, $urandom,
                $urandom_range(0, (rx_count > 0) ? rx_count - 1 : 0));
  endtask

  task automatic tx_seq(input int len);
    logic [7:0] d;
    int j;
    bus_echo.delete();
    if (tx_active) begin
      if ($urandom_range(0, 1) == 0) send_item(efl_pkg::OP_BEGIN, $urandom, $urandom);
      send_item(efl_pkg::OP_CHECK, $urandom, $urandom);
    end
    if (rx_open) send_item(efl_pkg::OP_LINE, code_stop, $urandom);
    if (rx_ready && $urandom_range(0, 7) != 0) send_item(efl_pkg::OP_STATUS, $urandom, $urandom);
    send_item(efl_pkg::OP_BEGIN, $urandom, $urandom);
    echo_line(2);
    for (j = 0; j < len; j++) begin
      d = 8'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: d = code_start;
          1: d = code_stop;
          default: d = code_escape;
        endcase
      end
      send_item(efl_pkg::OP_BYTE, d, $urandom);
      if ($urandom_range(0, 11) != 0) echo_line(4);
    end
    send_item(efl_pkg::OP_END, $urandom, $urandom);
    echo_line(2);
    if ($urandom_range(0, 9) != 0) send_item(efl_pkg::OP_CHECK, $urandom, $urandom);
    bus_echo.delete();
  endtask

  task automatic noise_burst();
    logic [7:0] d;
    repeat ($urandom_range(1, 5)) begin
      d = 8'($urandom);
      if ($urandom_range(0, 3) == 0) d = ($urandom_range(0, 1) == 0) ? code_start : code_stop;
      send_item(3'($urandom_range(0, 7)), d, $urandom);
    end
    if ($urandom_range(0, 2) == 0) echo_line(10);
    bus_echo.delete();
  endtask

  task automatic test_idle_ops();
    send_item(efl_pkg::OP_STATUS, 8'h00, 6'h00);
    send_item(OpUndef, 8'hFF, 6'h3F);
    send_item(efl_pkg::OP_BYTE, 8'hAA, 6'h15);
    send_item(efl_pkg::OP_END, 8'h55, 6'h2A);
    send_item(efl_pkg::OP_CHECK, 8'h00, 6'h00);
  endtask

  task automatic test_receive_deframing();
    send_item(efl_pkg::OP_LINE, efl_pkg::EscapeReset, 6'h00);
    send_item(efl_pkg::OP_LINE, efl_pkg::StartReset, 6'h00);
    send_item(efl_pkg::OP_LINE, 8'h41, 6'h00);
    send_item(efl_pkg::OP_LINE, efl_pkg::EscapeReset, 6'h00);
    send_item(efl_pkg::OP_LINE, 8'h7F, 6'h00);
    send_item(efl_pkg::OP_LINE, 8'h00, 6'h00);
    send_item(efl_pkg::OP_LINE, efl_pkg::StopReset, 6'h00);
    send_item(efl_pkg::OP_PEEK, 8'h00, 6'd0);
    send_item(efl_pkg::OP_PEEK, 8'h00, 6'd1);
    send_item(efl_pkg::OP_BEGIN, 8'h00, 6'h00);
    send_item(efl_pkg::OP_LINE, efl_pkg::StartReset, 6'h00);
    send_item(efl_pkg::OP_STATUS, 8'h00, 6'h00);
    send_item(efl_pkg::OP_LINE, efl_pkg::StopReset, 6'h00);
    send_item(efl_pkg::OP_STATUS, 8'h00, 6'h00);
  endtask

  task automatic test_send_and_echo();
    bus_echo.delete();
    send_item(efl_pkg::OP_BEGIN, 8'h00, 6'h00);
    send_item(efl_pkg::OP_BYTE, efl_pkg::StartReset, 6'h00);
    send_item(efl_pkg::OP_BYTE, 8'h00, 6'h00);
    send_item(efl_pkg::OP_LINE, 8'h55, 6'h00);
    send_item(efl_pkg::OP_BYTE, 8'h12, 6'h00);
    send_item(efl_pkg::OP_END, 8'h00, 6'h00);
    send_item(efl_pkg::OP_CHECK, 8'h00, 6'h00);
    // clean send with every byte echoed back
    bus_echo.delete();
    send_item(efl_pkg::OP_BEGIN, 8'h00, 6'h00);
    echo_line(0);
    send_item(efl_pkg::OP_BYTE, 8'h3C, 6'h00);
    echo_line(0);
    send_item(efl_pkg::OP_BYTE, efl_pkg::EscapeReset, 6'h00);
    echo_line(0);
    send_item(efl_pkg::OP_END, 8'h00, 6'h00);
    echo_line(0);
    send_item(efl_pkg::OP_CHECK, 8'h00, 6'h00);
  endtask

  task automatic test_code_extremes();
    set_codes(8'h00, 8'hFF, 8'h80, 8'd1);
    rx_frame_seq(4);
    tx_seq(3);
    set_codes(8'h7F, 8'h80, 8'hFF, 8'd64);
    rx_frame_seq(6);
    tx_seq(5);
  endtask

  task automatic test_random_traffic();
    int goal;
    int phase_end;
    int phase;
    logic [7:0] s, p, e, c;
    goal = 850;
    phase = 0;
    while (items_sent < goal) begin
      phase_end = items_sent + 110;
      idling = (goal - items_sent < 130) ? 0 : (phase % 3 != 2);
      while (items_sent < phase_end && items_sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: rx_frame_seq(pick_len());
          4, 5, 6, 7: tx_seq(pick_len());
          default:    noise_burst();
        endcase
      end
      s = 8'($urandom);
      do p = 8'($urandom); while (p == s);
      do e = 8'($urandom); while (e == s || e == p);
      case ($urandom_range(0, 3))
        0:       c = 8'd1;
        1:       c = 8'd64;
        default: c = 8'($urandom_range(1, 64));
      endcase
      set_codes(s, p, e, c);
      phase++;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ops();
    test_receive_deframing();
    test_send_and_echo();
    test_code_extremes();
    test_random_traffic();
    idling = 0;
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
